// ===== src/mf3_pkg.sv =====
// shared types and constants for the 3x3 rgb median filter
`timescale 1ns / 1ps

package mf3_pkg;

   // sample and window geometry
   localparam int SAMPLE_W = 8;
   localparam int TAPS     = 9;
   localparam int ROW_W    = 16;
   localparam int CFG_W_W  = 12;

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   typedef logic [SAMPLE_W-1:0]         sample_type;
   typedef logic [TAPS-1:0][SAMPLE_W-1:0] window9_type;
   typedef logic [CSR_IDX_W-1:0]        csr_index_type;

   // register indexes
   localparam csr_index_type CSR_IMAGE_WIDTH  = 4'd0;
   localparam csr_index_type CSR_IMAGE_HEIGHT = 4'd1;

   // register reset values and lower bounds
   localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd480;
   localparam int                 MIN_SIDE     = 3;

endpackage

// ===== src/mf3_if.sv =====
// stream and configuration interfaces of the median filter
`timescale 1ns / 1ps

interface mf3_req_if;
   logic                         valid;
   logic                         ready;
   logic [mf3_pkg::SAMPLE_W-1:0] pixel_blue;
   logic [mf3_pkg::SAMPLE_W-1:0] pixel_green;
   logic [mf3_pkg::SAMPLE_W-1:0] pixel_red;
   logic                         frame_start;

   modport source (output valid, pixel_blue, pixel_green, pixel_red, frame_start,
                   input ready);
   modport sink   (input valid, pixel_blue, pixel_green, pixel_red, frame_start,
                   output ready);
endinterface

interface mf3_rsp_if #(parameter int COL_W = 11);
   logic                         valid;
   logic                         ready;
   logic [mf3_pkg::SAMPLE_W-1:0] median_blue;
   logic [mf3_pkg::SAMPLE_W-1:0] median_green;
   logic [mf3_pkg::SAMPLE_W-1:0] median_red;
   logic [COL_W-1:0]             centre_column;
   logic [mf3_pkg::ROW_W-1:0]    centre_row;
   logic                         frame_last;

   modport source (output valid, median_blue, median_green, median_red,
                   centre_column, centre_row, frame_last, input ready);
   modport sink   (input valid, median_blue, median_green, median_red,
                   centre_column, centre_row, frame_last, output ready);
endinterface

interface mf3_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mf3_pkg::CSR_IDX_W-1:0]  index;
   logic [mf3_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/mf3_line_store.sv =====
// two row memories holding the two rows above the current one
`timescale 1ns / 1ps

module mf3_line_store #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 24
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_older,
   input  logic [DATA_W-1:0] wr_newer,
   output logic [DATA_W-1:0] rd_older,
   output logic [DATA_W-1:0] rd_newer
);

   logic [DATA_W-1:0] older_mem [DEPTH];
   logic [DATA_W-1:0] newer_mem [DEPTH];
   logic [DATA_W-1:0] rd_older_ff;
   logic [DATA_W-1:0] rd_newer_ff;

   // write port, row shift at one column
   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[wr_addr] <= wr_older;
         newer_mem[wr_addr] <= wr_newer;
      end
   end

   // registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_older_ff <= older_mem[rd_addr];
         rd_newer_ff <= newer_mem[rd_addr];
      end
   end

   assign rd_older = rd_older_ff;
   assign rd_newer = rd_newer_ff;

endmodule

// ===== src/mf3_median.sv =====
// two-stage median-of-nine network for one colour channel
`timescale 1ns / 1ps

module mf3_median (
   input  logic                 clock,
   input  logic                 advance,
   input  mf3_pkg::window9_type samples,
   output mf3_pkg::sample_type  median
);

   import mf3_pkg::*;

   window9_type sorted_ff;
   window9_type sorted_in;
   sample_type  median_ff;
   sample_type  median_in;

   // compare-exchange, result is {low, high}
   function automatic logic [2*SAMPLE_W-1:0] cswap(input sample_type a, input sample_type b);
      if (a > b) begin
         return {b, a};
      end
      return {a, b};
   endfunction

   // first half: sort each of the three triples
   always_comb begin
      sorted_in = samples;
      for (int t = 0; t < 3; t++) begin
         {sorted_in[3*t+1], sorted_in[3*t+2]} = cswap(sorted_in[3*t+1], sorted_in[3*t+2]);
         {sorted_in[3*t],   sorted_in[3*t+1]} = cswap(sorted_in[3*t],   sorted_in[3*t+1]);
         {sorted_in[3*t+1], sorted_in[3*t+2]} = cswap(sorted_in[3*t+1], sorted_in[3*t+2]);
      end
   end

   // second half: merge the sorted triples down to the middle value
   always_comb begin
      window9_type p;
      p = sorted_ff;
      {p[0], p[3]} = cswap(p[0], p[3]);
      {p[5], p[8]} = cswap(p[5], p[8]);
      {p[4], p[7]} = cswap(p[4], p[7]);
      {p[3], p[6]} = cswap(p[3], p[6]);
      {p[1], p[4]} = cswap(p[1], p[4]);
      {p[2], p[5]} = cswap(p[2], p[5]);
      {p[4], p[7]} = cswap(p[4], p[7]);
      {p[4], p[2]} = cswap(p[4], p[2]);
      {p[6], p[4]} = cswap(p[6], p[4]);
      {p[4], p[2]} = cswap(p[4], p[2]);
      median_in = p[4];
   end

   // stage registers move with the rest of the pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         sorted_ff <= sorted_in;
         median_ff <= median_in;
      end
   end

   assign median = median_ff;

endmodule

// ===== src/median_filter_3x3_rgb.sv =====
// Streaming 3x3 median filter over rgb pixels in raster order.
// Throughput: one pixel per cycle while the output is not stalled; the line memories take a
// read and a write each cycle. Pipeline: line memory read, window and triple sort, median
// merge; a result waits in the output register until it is taken.
// Reset: synchronous; position counters and window cleared, geometry 640 x 480,
// line memory contents left as they are.
`timescale 1ns / 1ps

module median_filter_3x3_rgb #(
   parameter int MAX_WIDTH = 2048,
   parameter int CHANNELS  = 3
) (
   input  logic                clock,
   input  logic                reset,
   mf3_req_if.sink             req_bus,
   mf3_rsp_if.source           rsp_bus,
   mf3_csr_if.sink             csr_bus
);

   import mf3_pkg::*;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WID_W   = $clog2(MAX_WIDTH + 1);
   localparam int USED_CH = (CHANNELS < 3) ? CHANNELS : 3;
   localparam int DATA_W  = SAMPLE_W * USED_CH;

   // configuration registers
   logic [CFG_W_W-1:0] cfg_width_ff;
   logic [ROW_W-1:0]   cfg_height_ff;
   logic [WID_W-1:0]   w_eff;
   logic [ROW_W-1:0]   h_eff;

   // position of the next pixel
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] pos_col;
   logic [ROW_W-1:0] pos_row;
   logic [ROW_W:0]   row_inc;
   logic [ROW_W:0]   pos_row_inc;
   logic [WID_W-1:0] pos_col_inc;
   logic             pos_emit;
   logic             pos_last;

   // handshake
   logic advance;
   logic accept;

   // stage 1: line memory data arriving
   logic              s1_valid_ff;
   logic [DATA_W-1:0] pix1_ff;
   logic [COL_W-1:0]  col1_ff;
   logic              emit1_ff;
   logic              last1_ff;
   logic [COL_W-1:0]  ccol1_ff;
   logic [ROW_W-1:0]  crow1_ff;
   logic              fwd1_ff;
   logic [DATA_W-1:0] fwd_older_ff;
   logic [DATA_W-1:0] fwd_newer_ff;
   logic [DATA_W-1:0] rd_older;
   logic [DATA_W-1:0] rd_newer;
   logic [DATA_W-1:0] older_eff;
   logic [DATA_W-1:0] newer_eff;
   logic [5:0][DATA_W-1:0] win_ff;

   // stage 2 and output stage
   logic              s2_valid_ff;
   logic              last2_ff;
   logic [COL_W-1:0]  ccol2_ff;
   logic [ROW_W-1:0]  crow2_ff;
   logic              rsp_valid_ff;
   logic              last_out_ff;
   logic [COL_W-1:0]  ccol_out_ff;
   logic [ROW_W-1:0]  crow_out_ff;

   logic [2:0][SAMPLE_W-1:0] all_pix;
   logic [DATA_W-1:0]        req_pix;
   logic [2:0][SAMPLE_W-1:0] med_all;

   // configuration writes, always accepted
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RESET;
         cfg_height_ff <= HEIGHT_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_IMAGE_WIDTH:  cfg_width_ff  <= csr_bus.data[CFG_W_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_height_ff <= csr_bus.data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp width to MIN_SIDE up to what the line memories support, height to at least MIN_SIDE
   always_comb begin
      if (32'(cfg_width_ff) < MIN_SIDE) begin
         w_eff = WID_W'(MIN_SIDE);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(cfg_width_ff);
      end
      if (32'(cfg_height_ff) < MIN_SIDE) begin
         h_eff = ROW_W'(MIN_SIDE);
      end else begin
         h_eff = cfg_height_ff;
      end
   end

   // position of the incoming pixel, with frame start and geometry wrap
   always_comb begin
      pos_col = col_ff;
      pos_row = row_ff;
      row_inc = {1'b0, row_ff} + 1'b1;
      if (req_bus.frame_start) begin
         pos_col = '0;
         pos_row = '0;
      end else if (WID_W'(col_ff) >= w_eff) begin
         pos_col = '0;
         if (row_inc >= {1'b0, h_eff}) begin
            pos_row = '0;
         end else begin
            pos_row = row_inc[ROW_W-1:0];
         end
      end else if (row_ff >= h_eff) begin
         pos_row = '0;
      end
   end

   // next position and result flags
   always_comb begin
      pos_col_inc = WID_W'(pos_col) + 1'b1;
      pos_row_inc = {1'b0, pos_row} + 1'b1;
      col_in = pos_col_inc[COL_W-1:0];
      row_in = pos_row;
      if (pos_col_inc >= w_eff) begin
         col_in = '0;
         if (pos_row_inc >= {1'b0, h_eff}) begin
            row_in = '0;
         end else begin
            row_in = pos_row_inc[ROW_W-1:0];
         end
      end
      pos_emit = (pos_col >= COL_W'(2)) && (pos_row >= ROW_W'(2));
      pos_last = (WID_W'(pos_col) == w_eff - 1'b1) && (pos_row == h_eff - 1'b1);
   end

   // whole pipeline moves when the output register is empty or being taken
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && advance;
   assign req_bus.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // pack the used channels, blue in the low byte
   assign all_pix = {req_bus.pixel_red, req_bus.pixel_green, req_bus.pixel_blue};
   assign req_pix = all_pix[USED_CH-1:0];

   mf3_line_store #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W),
      .DATA_W (DATA_W)
   ) u_line_store (
      .clock    (clock),
      .rd_en    (accept),
      .rd_addr  (pos_col),
      .wr_en    (s1_valid_ff && advance),
      .wr_addr  (col1_ff),
      .wr_older (newer_eff),
      .wr_newer (pix1_ff),
      .rd_older (rd_older),
      .rd_newer (rd_newer)
   );

   // stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   // stage 1 payload; forward when the column being written is read again
   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff      <= req_pix;
         col1_ff      <= pos_col;
         emit1_ff     <= pos_emit;
         last1_ff     <= pos_last;
         ccol1_ff     <= pos_col - 1'b1;
         crow1_ff     <= pos_row - 1'b1;
         fwd1_ff      <= s1_valid_ff && (pos_col == col1_ff);
         fwd_older_ff <= newer_eff;
         fwd_newer_ff <= pix1_ff;
      end
   end

   assign older_eff = fwd1_ff ? fwd_older_ff : rd_older;
   assign newer_eff = fwd1_ff ? fwd_newer_ff : rd_newer;

   // sliding window of the two previous columns
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_valid_ff && advance) begin
         win_ff[2:0] <= win_ff[5:3];
         win_ff[3]   <= older_eff;
         win_ff[4]   <= newer_eff;
         win_ff[5]   <= pix1_ff;
      end
   end

   // one median lane per used channel
   for (genvar c = 0; c < 3; c++) begin : g_lane
      if (c < USED_CH) begin : g_used
         window9_type samples;
         always_comb begin
            for (int i = 0; i < 6; i++) begin
               samples[i] = win_ff[i][SAMPLE_W*c +: SAMPLE_W];
            end
            samples[6] = older_eff[SAMPLE_W*c +: SAMPLE_W];
            samples[7] = newer_eff[SAMPLE_W*c +: SAMPLE_W];
            samples[8] = pix1_ff[SAMPLE_W*c +: SAMPLE_W];
         end
         mf3_median u_median (
            .clock   (clock),
            .advance (advance),
            .samples (samples),
            .median  (med_all[c])
         );
      end else begin : g_unused
         assign med_all[c] = '0;
      end
   end

   // stage 2 and output control
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= s1_valid_ff && emit1_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // coordinates travel alongside the median network
   always_ff @(posedge clock) begin
      if (advance) begin
         last2_ff    <= last1_ff;
         ccol2_ff    <= ccol1_ff;
         crow2_ff    <= crow1_ff;
         last_out_ff <= last2_ff;
         ccol_out_ff <= ccol2_ff;
         crow_out_ff <= crow2_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.median_blue   = med_all[0];
   assign rsp_bus.median_green  = med_all[1];
   assign rsp_bus.median_red    = med_all[2];
   assign rsp_bus.centre_column = ccol_out_ff;
   assign rsp_bus.centre_row    = crow_out_ff;
   assign rsp_bus.frame_last    = last_out_ff;

endmodule
